// ----- src/tlnt_pkg.sv -----
`timescale 1ns / 1ps
package tlnt_pkg;

   localparam int LEN_W = 7;
   localparam int LOCAL_SLOTS = 5;
   localparam int REMOTE_SLOTS = 4;

   localparam logic [7:0] CODE_IAC = 8'd255;
   localparam logic [7:0] CODE_DONT = 8'd254;
   localparam logic [7:0] CODE_DO = 8'd253;
   localparam logic [7:0] CODE_WONT = 8'd252;
   localparam logic [7:0] CODE_WILL = 8'd251;
   localparam logic [7:0] CODE_SB = 8'd250;
   localparam logic [7:0] CODE_SE = 8'd240;

   localparam logic [7:0] OPT_BINARY = 8'd0;
   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SUP_GA = 8'd3;
   localparam logic [7:0] OPT_LOCATION = 8'd23;
   localparam logic [7:0] OPT_TTYPE = 8'd24;
   localparam logic [7:0] OPT_TSPEED = 8'd32;
   localparam logic [7:0] SUB_SEND = 8'd1;

   localparam logic [1:0] MARK_NONE = 2'd0;
   localparam logic [1:0] MARK_ON = 2'd1;
   localparam logic [1:0] MARK_OFF = 2'd2;

   typedef enum logic [2:0] {
      KIND_DATA = 3'd0,
      KIND_REPLY = 3'd1,
      KIND_TTYPE = 3'd2,
      KIND_TSPEED = 3'd3,
      KIND_LOCATION = 3'd4
   } kind_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [7:0] cmd;
      logic [7:0] opt;
      logic [7:0] sub;
      logic [7:0] last;
      logic [7:0] blast;
      logic [LOCAL_SLOTS-1:0][1:0] lmark;
      logic [REMOTE_SLOTS-1:0][1:0] rmark;
   } state_type;

   typedef struct packed {
      kind_type kind;
      logic [7:0] data;
      logic [7:0] cmd;
      logic [7:0] opt;
   } result_type;

   typedef struct packed {
      logic hit;
      logic [2:0] idx;
   } local_slot_type;

   typedef struct packed {
      logic hit;
      logic [1:0] idx;
   } remote_slot_type;

   function automatic local_slot_type local_slot(input logic [7:0] opt);
      local_slot_type s;
      s.hit = 1'b1;
      s.idx = 3'd0;
      case (opt)
         OPT_BINARY: s.idx = 3'd0;
         OPT_ECHO: s.idx = 3'd1;
         OPT_TTYPE: s.idx = 3'd2;
         OPT_TSPEED: s.idx = 3'd3;
         OPT_SUP_GA: s.idx = 3'd4;
         default: s.hit = 1'b0;
      endcase
      return s;
   endfunction

   function automatic remote_slot_type remote_slot(input logic [7:0] opt);
      remote_slot_type s;
      s.hit = 1'b1;
      s.idx = 2'd0;
      case (opt)
         OPT_BINARY: s.idx = 2'd0;
         OPT_ECHO: s.idx = 2'd1;
         OPT_TTYPE: s.idx = 2'd2;
         OPT_SUP_GA: s.idx = 2'd3;
         default: s.hit = 1'b0;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] ack_of(input logic [7:0] cmd);
      logic [7:0] r;
      case (cmd)
         CODE_DO: r = CODE_WILL;
         CODE_DONT: r = CODE_WONT;
         CODE_WILL: r = CODE_DO;
         default: r = CODE_DONT;
      endcase
      return r;
   endfunction

endpackage

// ----- src/telnet_receive_option_negotiator.sv -----
`timescale 1ns / 1ps
// an accepted request beat passes through the input register, then the decode logic, then the response register
// throughput: one beat per cycle while the response side is not stalled, set by the single input
// register feeding the decode logic and the response register
// reset: synchronous, clears the command length, held bytes and option marks;
// bytes that cause no response are consumed silently
module telnet_receive_option_negotiator #(
   parameter int SEQUENCE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic [0:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_byte, reply_command, reply_option
   output logic [2:0]  rsp_tuser    // result_kind
);

   logic in_valid_ff, in_valid_in;
   logic in_mode_ff;
   logic [7:0] in_byte_ff;
   logic rsp_valid_ff, rsp_valid_in;
   tlnt_pkg::result_type rsp_ff;
   tlnt_pkg::state_type state_ff, state_in;
   tlnt_pkg::state_type step_nxt;
   tlnt_pkg::result_type step_res;
   logic step_emit;
   logic out_free;
   logic proc;

   tlnt_step #(
      .SEQUENCE_DEPTH(SEQUENCE_DEPTH)
   ) u_step (
      .cur(state_ff),
      .mode(in_mode_ff),
      .rx_byte(in_byte_ff),
      .nxt(step_nxt),
      .emit(step_emit),
      .res(step_res)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign proc = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || proc;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) in_valid_in = req_tvalid;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) rsp_valid_in = proc && step_emit;
      state_in = proc ? step_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff <= req_tuser[0];
         in_byte_ff <= req_tdata;
      end
      if (proc && step_emit) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_ff.opt, rsp_ff.cmd, rsp_ff.data};
   assign rsp_tuser = rsp_ff.kind;

endmodule

// ----- src/tlnt_step.sv -----
`timescale 1ns / 1ps
module tlnt_step #(
   parameter int SEQUENCE_DEPTH = 64
) (
   input  tlnt_pkg::state_type  cur,
   input  logic                 mode,
   input  logic [7:0]           rx_byte,
   output tlnt_pkg::state_type  nxt,
   output logic                 emit,
   output tlnt_pkg::result_type res
);

   localparam logic [tlnt_pkg::LEN_W-1:0] DEPTH = tlnt_pkg::LEN_W'(SEQUENCE_DEPTH);

   logic store;
   logic [7:0] code_cmd;
   logic [1:0] code;
   tlnt_pkg::local_slot_type ls;
   tlnt_pkg::remote_slot_type rs;

   always_comb begin
      nxt = cur;
      emit = 1'b0;
      res = '0;
      store = 1'b0;
      code_cmd = '0;
      code = tlnt_pkg::MARK_NONE;
      ls = '0;
      rs = '0;
      if (mode) begin
         nxt.len = '0;
         nxt.lmark = '0;
         nxt.rmark = '0;
      end else if (cur.len == '0 && rx_byte != tlnt_pkg::CODE_IAC) begin
         emit = 1'b1;
         res.kind = tlnt_pkg::KIND_DATA;
         res.data = rx_byte;
      end else if (rx_byte == tlnt_pkg::CODE_IAC && cur.len == tlnt_pkg::LEN_W'(1)) begin
         nxt.len = '0;
         emit = 1'b1;
         res.kind = tlnt_pkg::KIND_DATA;
         res.data = tlnt_pkg::CODE_IAC;
      end else begin
         store = cur.len < DEPTH;
         if (store) begin
            if (cur.len == tlnt_pkg::LEN_W'(1)) nxt.cmd = rx_byte;
            if (cur.len == tlnt_pkg::LEN_W'(2)) nxt.opt = rx_byte;
            if (cur.len == tlnt_pkg::LEN_W'(3)) nxt.sub = rx_byte;
            nxt.blast = cur.last;
            nxt.last = rx_byte;
            nxt.len = cur.len + tlnt_pkg::LEN_W'(1);
         end
         if (nxt.len >= tlnt_pkg::LEN_W'(2) && nxt.cmd == tlnt_pkg::CODE_SB) begin
            if (rx_byte == tlnt_pkg::CODE_SE && nxt.blast == tlnt_pkg::CODE_IAC) begin
               nxt.len = '0;
               if (nxt.sub == tlnt_pkg::SUB_SEND) begin
                  if (nxt.opt == tlnt_pkg::OPT_TTYPE) begin
                     emit = 1'b1;
                     res.kind = tlnt_pkg::KIND_TTYPE;
                     res.opt = nxt.opt;
                  end else if (nxt.opt == tlnt_pkg::OPT_TSPEED) begin
                     emit = 1'b1;
                     res.kind = tlnt_pkg::KIND_TSPEED;
                     res.opt = nxt.opt;
                  end
               end
            end
         end else if (nxt.len == tlnt_pkg::LEN_W'(2) && rx_byte < tlnt_pkg::CODE_WILL) begin
            nxt.len = '0;
         end else if (nxt.len >= tlnt_pkg::LEN_W'(3)) begin
            nxt.len = '0;
            code_cmd = nxt.cmd;
            code = (code_cmd == tlnt_pkg::CODE_DO || code_cmd == tlnt_pkg::CODE_WILL)
                   ? tlnt_pkg::MARK_ON : tlnt_pkg::MARK_OFF;
            res.opt = nxt.opt;
            res.kind = tlnt_pkg::KIND_REPLY;
            if (code_cmd == tlnt_pkg::CODE_DO || code_cmd == tlnt_pkg::CODE_DONT) begin
               ls = tlnt_pkg::local_slot(nxt.opt);
               if (ls.hit) begin
                  if (cur.lmark[ls.idx] != code) begin
                     nxt.lmark[ls.idx] = code;
                     emit = 1'b1;
                     res.cmd = tlnt_pkg::ack_of(code_cmd);
                  end
               end else if (nxt.opt == tlnt_pkg::OPT_LOCATION) begin
                  emit = 1'b1;
                  if (code_cmd == tlnt_pkg::CODE_DO) begin
                     res.kind = tlnt_pkg::KIND_LOCATION;
                  end else begin
                     res.cmd = tlnt_pkg::CODE_WONT;
                  end
               end else if (code_cmd == tlnt_pkg::CODE_DO) begin
                  emit = 1'b1;
                  res.cmd = tlnt_pkg::CODE_WONT;
               end
            end else begin
               rs = tlnt_pkg::remote_slot(nxt.opt);
               if (rs.hit) begin
                  if (cur.rmark[rs.idx] != code) begin
                     nxt.rmark[rs.idx] = code;
                     emit = 1'b1;
                     res.cmd = tlnt_pkg::ack_of(code_cmd);
                  end
               end else if (code_cmd == tlnt_pkg::CODE_WILL) begin
                  emit = 1'b1;
                  res.cmd = tlnt_pkg::CODE_DONT;
               end
            end
         end
      end
   end

endmodule

// ----- tb/negotiation_checker.sv -----
`timescale 1ns / 1ps
module negotiation_checker #(
   parameter int SEQUENCE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic [0:0]  req_tuser,   // mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // out_byte, reply_command, reply_option
   input  logic [2:0]  rsp_tuser,   // result_kind
   output int          mismatches,
   output int          replies_pending,
   output int          data_seen,
   output int          replies_seen,
   output int          reports_seen
);
   import tlnt_pkg::*;

   logic [LEN_W-1:0] cmd_len;
   logic [7:0] cmd_byte;
   logic [7:0] opt_byte;
   logic [7:0] sub_byte;
   logic [7:0] newest;
   logic [7:0] second_newest;
   logic [1:0] do_marks [LOCAL_SLOTS];
   logic [1:0] will_marks [REMOTE_SLOTS];
   result_type replies_due [$];

   function automatic int do_slot(input logic [7:0] opt);
      case (opt)
         OPT_BINARY: return 0;
         OPT_ECHO: return 1;
         OPT_TTYPE: return 2;
         OPT_TSPEED: return 3;
         OPT_SUP_GA: return 4;
         default: return -1;
      endcase
   endfunction

   function automatic int will_slot(input logic [7:0] opt);
      case (opt)
         OPT_BINARY: return 0;
         OPT_ECHO: return 1;
         OPT_TTYPE: return 2;
         OPT_SUP_GA: return 3;
         default: return -1;
      endcase
   endfunction

   task automatic clear_marks();
      foreach (do_marks[i]) do_marks[i] = MARK_NONE;
      foreach (will_marks[i]) will_marks[i] = MARK_NONE;
   endtask

   // answer a complete three-byte option command held in cmd_byte/opt_byte
   task automatic answer_option(inout result_type r, inout logic produce);
      logic [1:0] code;
      int s;
      if (cmd_byte == CODE_DO || cmd_byte == CODE_DONT) begin
         code = (cmd_byte == CODE_DO) ? MARK_ON : MARK_OFF;
         s = do_slot(opt_byte);
         if (s >= 0) begin
            if (do_marks[s] != code) begin
               do_marks[s] = code;
               r.kind = KIND_REPLY;
               r.cmd = (cmd_byte == CODE_DO) ? CODE_WILL : CODE_WONT;
               r.opt = opt_byte;
               produce = 1'b1;
            end
         end else if (opt_byte == OPT_LOCATION) begin
            r.opt = opt_byte;
            produce = 1'b1;
            if (cmd_byte == CODE_DO) begin
               r.kind = KIND_LOCATION;
            end else begin
               r.kind = KIND_REPLY;
               r.cmd = CODE_WONT;
            end
         end else if (cmd_byte == CODE_DO) begin
            r.kind = KIND_REPLY;
            r.cmd = CODE_WONT;
            r.opt = opt_byte;
            produce = 1'b1;
         end
      end else begin
         code = (cmd_byte == CODE_WILL) ? MARK_ON : MARK_OFF;
         s = will_slot(opt_byte);
         if (s >= 0) begin
            if (will_marks[s] != code) begin
               will_marks[s] = code;
               r.kind = KIND_REPLY;
               r.cmd = (cmd_byte == CODE_WILL) ? CODE_DO : CODE_DONT;
               r.opt = opt_byte;
               produce = 1'b1;
            end
         end else if (cmd_byte == CODE_WILL) begin
            r.kind = KIND_REPLY;
            r.cmd = CODE_DONT;
            r.opt = opt_byte;
            produce = 1'b1;
         end
      end
   endtask

   task automatic predict_rx_beat(input logic mode, input logic [7:0] b);
      result_type r;
      logic produce;
      r.kind = KIND_DATA;
      r.data = '0;
      r.cmd = '0;
      r.opt = '0;
      produce = 1'b0;
      if (mode) begin
         cmd_len = '0;
         clear_marks();
      end else if (cmd_len == 0 && b != CODE_IAC) begin
         r.data = b;
         produce = 1'b1;
      end else if (b == CODE_IAC && cmd_len == 1) begin
         // doubled escape is a literal data byte
         cmd_len = '0;
         r.data = CODE_IAC;
         produce = 1'b1;
      end else begin
         if (cmd_len < SEQUENCE_DEPTH) begin
            case (cmd_len)
               1: cmd_byte = b;
               2: opt_byte = b;
               3: sub_byte = b;
               default: ;
            endcase
            second_newest = newest;
            newest = b;
            cmd_len = cmd_len + 1'b1;
         end
         if (cmd_len >= 2 && cmd_byte == CODE_SB) begin
            if (b == CODE_SE && second_newest == CODE_IAC) begin
               cmd_len = '0;
               if (sub_byte == SUB_SEND && opt_byte == OPT_TTYPE) begin
                  r.kind = KIND_TTYPE;
                  r.opt = opt_byte;
                  produce = 1'b1;
               end else if (sub_byte == SUB_SEND && opt_byte == OPT_TSPEED) begin
                  r.kind = KIND_TSPEED;
                  r.opt = opt_byte;
                  produce = 1'b1;
               end
            end
         end else if (cmd_len == 2 && b < CODE_WILL) begin
            cmd_len = '0;
         end else if (cmd_len >= 3) begin
            cmd_len = '0;
            answer_option(r, produce);
         end
      end
      if (produce) replies_due.push_back(r);
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         cmd_len = '0;
         cmd_byte = '0;
         opt_byte = '0;
         sub_byte = '0;
         newest = '0;
         second_newest = '0;
         clear_marks();
         replies_due.delete();
         mismatches = 0;
         data_seen = 0;
         replies_seen = 0;
         reports_seen = 0;
      end else begin
         if (req_tvalid && req_tready) predict_rx_beat(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.kind = kind_type'(rsp_tuser);
            got.data = rsp_tdata[7:0];
            got.cmd = rsp_tdata[15:8];
            got.opt = rsp_tdata[23:16];
            if (replies_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response beat: kind %0d data %h cmd %0d opt %0d",
                           got.kind, got.data, got.cmd, got.opt);
            end else begin
               want = replies_due.pop_front();
               if (got.kind !== want.kind || got.data !== want.data ||
                   got.cmd !== want.cmd || got.opt !== want.opt) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response mismatch: expected kind %0d data %h cmd %0d opt %0d, got kind %0d data %h cmd %0d opt %0d",
                              want.kind, want.data, want.cmd, want.opt,
                              got.kind, got.data, got.cmd, got.opt);
               end
               if (want.kind == KIND_DATA) data_seen++;
               else if (want.kind == KIND_REPLY) replies_seen++;
               else reports_seen++;
            end
         end
      end
      replies_pending = replies_due.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import tlnt_pkg::*;

   localparam int DEPTH = 64;
   localparam int IDLE_MAX = 19;
   localparam int RANDOM_BEATS = 1600;
   localparam int STALL_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // rx_byte
   logic [0:0]  req_tuser;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // out_byte, reply_command, reply_option
   logic [2:0]  rsp_tuser;   // result_kind

   int mismatches;
   int replies_pending;
   int data_seen;
   int replies_seen;
   int reports_seen;
   int beats_sent = 0;
   int call_starts = 0;
   int overruns = 0;
   int stall_cycles = 0;
   logic quiet = 1'b0;

   telnet_receive_option_negotiator #(.SEQUENCE_DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   negotiation_checker #(.SEQUENCE_DEPTH(DEPTH)) reply_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .mismatches(mismatches),
      .replies_pending(replies_pending),
      .data_seen(data_seen),
      .replies_seen(replies_seen),
      .reports_seen(reports_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int idle_cycles();
      if (quiet) return 0;
      return $urandom_range(0, IDLE_MAX);
   endfunction

   task automatic send_beat(input logic mode, input logic [7:0] rx);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= rx;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      if (mode) call_starts++;
   endtask

   task automatic send_byte(input logic [7:0] rx);
      send_beat(1'b0, rx);
   endtask

   task automatic send_option(input logic [7:0] cmd, input logic [7:0] opt);
      send_byte(CODE_IAC);
      send_byte(cmd);
      send_byte(opt);
   endtask

   task automatic send_subneg(input logic [7:0] opt, input logic [7:0] sub, input int body_len);
      send_byte(CODE_IAC);
      send_byte(CODE_SB);
      send_byte(opt);
      send_byte(sub);
      repeat (body_len) send_byte(8'($urandom_range(0, 254)));
      send_byte(CODE_IAC);
      send_byte(CODE_SE);
   endtask

   // fill the command store so the escape lands at its second to last slot
   task automatic send_overrun_subneg(input logic [7:0] opt);
      int extra;
      extra = $urandom_range(1, 5);
      send_byte(CODE_IAC);
      send_byte(CODE_SB);
      send_byte(opt);
      send_byte(SUB_SEND);
      repeat (DEPTH - 6) send_byte(8'($urandom_range(0, 239)));
      send_byte(CODE_IAC);
      repeat (extra) send_byte(8'($urandom_range(0, 239)));
      if ($urandom_range(0, 1)) send_byte(CODE_IAC);
      send_byte(CODE_SE);
      overruns++;
   endtask

   function automatic logic [7:0] any_command();
      case ($urandom_range(0, 3))
         0: return CODE_WILL;
         1: return CODE_WONT;
         2: return CODE_DO;
         default: return CODE_DONT;
      endcase
   endfunction

   function automatic logic [7:0] any_option();
      case ($urandom_range(0, 9))
         0: return OPT_BINARY;
         1: return OPT_ECHO;
         2: return OPT_SUP_GA;
         3: return OPT_LOCATION;
         4: return OPT_TTYPE;
         5: return OPT_TSPEED;
         6: return OPT_TTYPE;
         7: return OPT_ECHO;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] any_report_option();
      case ($urandom_range(0, 3))
         0: return OPT_TTYPE;
         1: return OPT_TSPEED;
         2: return OPT_LOCATION;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int pick;
      int last_phase;
      logic paused;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      last_phase = 0;
      paused = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h00);
      send_byte(8'hFE);
      send_byte(CODE_IAC);
      send_byte(CODE_IAC);
      send_option(CODE_DO, OPT_TTYPE);
      send_option(CODE_DO, OPT_TTYPE);
      send_option(CODE_WILL, 8'd200);
      send_option(CODE_DO, OPT_LOCATION);
      send_subneg(OPT_TSPEED, SUB_SEND, 0);
      send_byte(CODE_IAC);
      send_byte(8'd241);
      send_beat(1'b1, 8'h00);

      while (beats_sent < RANDOM_BEATS + 25) begin
         if (beats_sent / 150 != last_phase) begin
            last_phase = beats_sent / 150;
            quiet = ($urandom_range(0, 3) == 0);
         end
         if (!paused && beats_sent > RANDOM_BEATS / 2) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            do @(negedge clock); while (replies_pending != 0);
            @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 254)));
         end else if (pick < 38) begin
            send_byte(CODE_IAC);
            send_byte(CODE_IAC);
         end else if (pick < 68) begin
            send_option(any_command(), any_option());
         end else if (pick < 80) begin
            send_subneg(any_report_option(),
                        $urandom_range(0, 3) != 0 ? SUB_SEND : 8'($urandom_range(0, 255)),
                        $urandom_range(0, 6));
         end else if (pick < 83) begin
            send_overrun_subneg($urandom_range(0, 1) ? OPT_TTYPE : OPT_TSPEED);
         end else if (pick < 84) begin
            // store overrun that never closes, then call start
            send_byte(CODE_IAC);
            send_byte(CODE_SB);
            repeat (DEPTH + 8) send_byte(8'($urandom_range(0, 254)));
            send_byte(CODE_SE);
            send_beat(1'b1, 8'($urandom_range(0, 255)));
         end else if (pick < 90) begin
            send_beat(1'b1, 8'($urandom_range(0, 255)));
         end else if (pick < 95) begin
            send_byte(CODE_IAC);
            send_byte(8'($urandom_range(0, 255)));
         end else begin
            // broken option command cut off by a call start
            send_byte(CODE_IAC);
            send_byte(any_command());
            send_beat(1'b1, 8'($urandom_range(0, 255)));
         end
      end

      req_tvalid <= 1'b0;
      do @(negedge clock); while (replies_pending != 0);
      repeat (8) @(posedge clock);
      $display("covered %0d request beats, %0d call starts, %0d store overruns",
               beats_sent, call_starts, overruns);
      $display("checked %0d data beats, %0d negotiation replies, %0d report requests",
               data_seen, replies_seen, reports_seen);
      if (mismatches == 0 && replies_pending == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      int gap;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = idle_cycles();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

endmodule

// ----- filelist.f -----
src/tlnt_pkg.sv
src/tlnt_step.sv
src/telnet_receive_option_negotiator.sv
tb/negotiation_checker.sv
tb/tb.sv
